[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TPS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tps assertion failed");

// next-cycle implication
`define TPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tps assertion failed");

`endif

[sv/tps_pkg.sv]
// ----------------------------------------------------------------------------
// tps_pkg
// Constants and codes shared by the trajectory point sequencer.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int MAX_POINTS_DEF = 64;
   localparam int JOINTS_DEF     = 6;
   localparam int NUM_JOINT_PORTS = 6;

   localparam int TIME_W = 24;
   localparam int POS_W  = 32;
   localparam int CSR_AW = 4;
   localparam int CSR_IW = 2;

   // commands
   localparam logic [2:0] CMD_LOAD     = 3'd0;
   localparam logic [2:0] CMD_START    = 3'd1;
   localparam logic [2:0] CMD_STOP     = 3'd2;
   localparam logic [2:0] CMD_FEEDBACK = 3'd3;
   localparam logic [2:0] CMD_TICK     = 3'd4;

   // result status codes
   localparam logic [3:0] ST_IDLE        = 4'd0;
   localparam logic [3:0] ST_WAIT        = 4'd1;
   localparam logic [3:0] ST_PUBLISH     = 4'd2;
   localparam logic [3:0] ST_AWAIT       = 4'd3;
   localparam logic [3:0] ST_FINISHED    = 4'd4;
   localparam logic [3:0] ST_NO_FEEDBACK = 4'd5;
   localparam logic [3:0] ST_FB_TIMEOUT  = 4'd6;
   localparam logic [3:0] ST_EXEC_TIMEOUT = 4'd7;
   localparam logic [3:0] ST_OK          = 4'd8;
   localparam logic [3:0] ST_REJ_BUSY    = 4'd9;
   localparam logic [3:0] ST_REJ_EMPTY   = 4'd10;
   localparam logic [3:0] ST_REJ_INVALID = 4'd11;

   // register indexes
   localparam logic [CSR_IW-1:0] REG_GOAL_TOL  = 2'd0;
   localparam logic [CSR_IW-1:0] REG_EXEC_TMO  = 2'd1;
   localparam logic [CSR_IW-1:0] REG_FB_TMO    = 2'd2;
   localparam logic [CSR_IW-1:0] REG_MIN_INTV  = 2'd3;

   // defaults, also used when a register holds zero
   localparam logic [30:0]       DEF_GOAL_TOL = 31'd10486;
   localparam logic [TIME_W-1:0] DEF_EXEC_TMO = 24'd15000;
   localparam logic [TIME_W-1:0] DEF_FB_TMO   = 24'd1000;
   localparam logic [TIME_W-1:0] DEF_MIN_INTV = 24'd20;

   // progress in permille
   localparam int PROG_BASE  = 300;
   localparam int PROG_SPAN  = 650;
   localparam int PROG_CAP   = 950;

endpackage

[sv/tps_if.sv]
// ----------------------------------------------------------------------------
// tps channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface tps_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         cmd;
   logic [23:0]        point_time_ms;
   logic [23:0]        task_timeout_ms;
   logic signed [31:0] joint_0;
   logic signed [31:0] joint_1;
   logic signed [31:0] joint_2;
   logic signed [31:0] joint_3;
   logic signed [31:0] joint_4;
   logic signed [31:0] joint_5;

   modport source (output valid, cmd, point_time_ms, task_timeout_ms,
                   joint_0, joint_1, joint_2, joint_3, joint_4, joint_5,
                   input ready);
   modport sink   (input valid, cmd, point_time_ms, task_timeout_ms,
                   joint_0, joint_1, joint_2, joint_3, joint_4, joint_5,
                   output ready);
endinterface

interface tps_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         status;
   logic signed [31:0] cmd_pos_0;
   logic signed [31:0] cmd_pos_1;
   logic signed [31:0] cmd_pos_2;
   logic signed [31:0] cmd_pos_3;
   logic signed [31:0] cmd_pos_4;
   logic signed [31:0] cmd_pos_5;
   logic [23:0]        interval_ms;
   logic [9:0]         progress_permille;
   logic [31:0]        peak_error;

   modport source (output valid, status, cmd_pos_0, cmd_pos_1, cmd_pos_2, cmd_pos_3,
                   cmd_pos_4, cmd_pos_5, interval_ms, progress_permille, peak_error,
                   input ready);
   modport sink   (input valid, status, cmd_pos_0, cmd_pos_1, cmd_pos_2, cmd_pos_3,
                   cmd_pos_4, cmd_pos_5, interval_ms, progress_permille, peak_error,
                   output ready);
endinterface

[sv/tps_ram.sv]
// ----------------------------------------------------------------------------
// tps_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/tps_div.sv]
// ----------------------------------------------------------------------------
// tps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tps_div #(
   parameter int NUM_W = 17,
   parameter int DEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [DEN_W:0]   rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

[sv/trajectory_point_sequencer.sv]
// ----------------------------------------------------------------------------
// trajectory_point_sequencer
// Stores a joint trajectory and plays it out point by point on 1 ms ticks.
// ----------------------------------------------------------------------------
// Usage:
//  req_ch carries command items (load point, start, stop, joint feedback,
//  tick); rsp_ch returns exactly one result item per command item.
//  Registers sit on an APB port (tolerance, exec timeout, feedback timeout,
//  minimum interval) at byte addresses 0, 4, 8, 12; write them while idle.
//  A load writes the point's joints one at a time. A tick while active walks
//  the final point's joints if feedback is held, reads two point times if
//  points remain, on publish reads the point joint by joint, then runs the
//  progress division (one quotient bit per cycle, CNT_W + 10 bits). One item
//  is in work at a time, as req_ch is ready only in the idle state.
//  A result waits in an output register; if rsp_ch stalls, the next item is
//  still accepted and worked on, and its result is held until the first one
//  is taken.
//  Reset (synchronous) clears control state and loads register defaults;
//  point storage is not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trajectory_point_sequencer #(
   parameter int MAX_POINTS = tps_pkg::MAX_POINTS_DEF,
   parameter int JOINTS     = tps_pkg::JOINTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   tps_req_if.sink                     req_ch,
   tps_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tps_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int TAW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int PDEPTH = MAX_POINTS * JOINTS;
   localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
   localparam int JW     = (JOINTS > 1) ? $clog2(JOINTS) : 1;
   localparam int NUM_W  = CNT_W + 10;
   localparam int TW     = tps_pkg::TIME_W;
   localparam int PW     = tps_pkg::POS_W;
   localparam int NJP    = tps_pkg::NUM_JOINT_PORTS;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_LOAD   = 13'b0000000000010,
      S_ERR_A  = 13'b0000000000100,
      S_ERR_B  = 13'b0000000001000,
      S_DECIDE = 13'b0000000010000,
      S_TIM_A  = 13'b0000000100000,
      S_TIM_B  = 13'b0000001000000,
      S_TIM_C  = 13'b0000010000000,
      S_TIM_D  = 13'b0000100000000,
      S_POS_A  = 13'b0001000000000,
      S_POS_B  = 13'b0010000000000,
      S_DIV    = 13'b0100000000000,
      S_OUT    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [30:0]   tol_ff, tol_in;
   logic [TW-1:0] dexec_ff, dexec_in;
   logic [TW-1:0] fbto_ff, fbto_in;
   logic [TW-1:0] minint_ff, minint_in;

   // sequencer control state
   logic             active_ff, active_in;
   logic [CNT_W-1:0] pc_ff, pc_in;
   logic [CNT_W-1:0] ni_ff, ni_in;
   logic             has_fb_ff, has_fb_in;
   logic [TW-1:0]    age_ff, age_in;
   logic [TW-1:0]    elapsed_ff, elapsed_in;
   logic [TW-1:0]    task_to_ff, task_to_in;
   logic [JW-1:0]    jcnt_ff, jcnt_in;
   logic             div_start;
   logic             rsp_valid_ff, rsp_valid_in;

   // divider handshake tracking
   logic             div_busy_ff, div_busy_in;

   // payload and scratch
   logic signed [PW-1:0] jin_ff [JOINTS];
   logic signed [PW-1:0] jin_in [JOINTS];
   logic signed [PW-1:0] fb_ff  [JOINTS];
   logic signed [PW-1:0] fb_in  [JOINTS];
   logic signed [PW-1:0] res_pos_ff [JOINTS];
   logic signed [PW-1:0] res_pos_in [JOINTS];
   logic [PAW-1:0]   paddr_ff, paddr_in;
   logic [TAW-1:0]   taddr_ff, taddr_in;
   logic [TW-1:0]    prev_ff, prev_in;
   logic [3:0]       res_st_ff, res_st_in;
   logic [TW-1:0]    res_intv_ff, res_intv_in;
   logic [9:0]       res_prog_ff, res_prog_in;
   logic [31:0]      res_err_ff, res_err_in;
   logic [3:0]       o_st_ff, o_st_in;
   logic signed [PW-1:0] o_pos_ff [NJP];
   logic signed [PW-1:0] o_pos_in [NJP];
   logic [TW-1:0]    o_intv_ff, o_intv_in;
   logic [9:0]       o_prog_ff, o_prog_in;
   logic [31:0]      o_err_ff, o_err_in;

   // memories
   logic              t_we;
   logic [TW-1:0]     t_rdata;
   logic              p_we;
   logic [PW-1:0]     p_rdata;

   // combinational helpers
   logic                 req_acc;
   logic                 rsp_acc;
   logic signed [PW-1:0] jport [NJP];
   logic signed [PW:0]   diff;
   logic [PW:0]          adiff;
   logic [TW-1:0]        fbto_eff;
   logic [TW-1:0]        minint_eff;
   logic [30:0]          tol_eff;
   logic [NUM_W-1:0]     div_num;
   logic [NUM_W-1:0]     div_quot;
   logic                 div_done;
   logic [NUM_W:0]       prog_sum;
   logic [tps_pkg::CSR_IW-1:0] wr_idx;

   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);

   assign jport[0] = req_ch.joint_0;
   assign jport[1] = req_ch.joint_1;
   assign jport[2] = req_ch.joint_2;
   assign jport[3] = req_ch.joint_3;
   assign jport[4] = req_ch.joint_4;
   assign jport[5] = req_ch.joint_5;

   assign fbto_eff   = (fbto_ff   != '0) ? fbto_ff   : tps_pkg::DEF_FB_TMO;
   assign minint_eff = (minint_ff != '0) ? minint_ff : tps_pkg::DEF_MIN_INTV;
   assign tol_eff    = (tol_ff    != '0) ? tol_ff    : tps_pkg::DEF_GOAL_TOL;

   // 650 * index, a constant multiply on a narrow value
   assign div_num  = NUM_W'(32'(ni_ff) * tps_pkg::PROG_SPAN);
   assign prog_sum = (NUM_W + 1)'(div_quot) + (NUM_W + 1)'(tps_pkg::PROG_BASE);

   // joint error for the current walk step
   assign diff  = (PW + 1)'(fb_ff[jcnt_ff]) - (PW + 1)'($signed(p_rdata));
   assign adiff = diff[PW] ? (PW + 1)'(-diff) : (PW + 1)'(diff);

   // ------------------------------------------------------------------
   // APB register port
   // ------------------------------------------------------------------
   assign pready = 1'b1;
   assign wr_idx = paddr[tps_pkg::CSR_AW-1:2];

   always_comb begin
      tol_in    = tol_ff;
      dexec_in  = dexec_ff;
      fbto_in   = fbto_ff;
      minint_in = minint_ff;
      if (psel && penable && pwrite) begin
         case (wr_idx)
            tps_pkg::REG_GOAL_TOL: tol_in    = pwdata[30:0];
            tps_pkg::REG_EXEC_TMO: dexec_in  = pwdata[TW-1:0];
            tps_pkg::REG_FB_TMO:   fbto_in   = pwdata[TW-1:0];
            tps_pkg::REG_MIN_INTV: minint_in = pwdata[TW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (wr_idx)
         tps_pkg::REG_GOAL_TOL: prdata = {1'b0, tol_ff};
         tps_pkg::REG_EXEC_TMO: prdata = {8'd0, dexec_ff};
         tps_pkg::REG_FB_TMO:   prdata = {8'd0, fbto_ff};
         tps_pkg::REG_MIN_INTV: prdata = {8'd0, minint_ff};
         default:               prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in    = state_ff;
      active_in   = active_ff;
      pc_in       = pc_ff;
      ni_in       = ni_ff;
      has_fb_in   = has_fb_ff;
      age_in      = age_ff;
      elapsed_in  = elapsed_ff;
      task_to_in  = task_to_ff;
      jcnt_in     = jcnt_ff;
      jin_in      = jin_ff;
      fb_in       = fb_ff;
      res_pos_in  = res_pos_ff;
      paddr_in    = paddr_ff;
      taddr_in    = taddr_ff;
      prev_in     = prev_ff;
      res_st_in   = res_st_ff;
      res_intv_in = res_intv_ff;
      res_prog_in = res_prog_ff;
      res_err_in  = res_err_ff;
      t_we        = 1'b0;
      p_we        = 1'b0;
      div_start   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               // every result starts from a cleared payload
               res_st_in   = tps_pkg::ST_OK;
               res_intv_in = '0;
               res_prog_in = '0;
               res_err_in  = '0;
               for (int j = 0; j < JOINTS; j++) begin
                  res_pos_in[j] = '0;
                  jin_in[j]     = jport[j];
               end
               state_in = S_OUT;
               case (req_ch.cmd)
                  tps_pkg::CMD_LOAD: begin
                     if (active_ff) begin
                        res_st_in = tps_pkg::ST_REJ_BUSY;
                     end else if (32'(pc_ff) >= MAX_POINTS) begin
                        res_st_in = tps_pkg::ST_REJ_INVALID;
                     end else begin
                        t_we     = 1'b1;
                        paddr_in = PAW'(32'(pc_ff) * JOINTS);
                        jcnt_in  = '0;
                        state_in = S_LOAD;
                     end
                  end
                  tps_pkg::CMD_START: begin
                     if (active_ff) begin
                        res_st_in = tps_pkg::ST_REJ_BUSY;
                     end else if (pc_ff == '0) begin
                        res_st_in = tps_pkg::ST_REJ_EMPTY;
                     end else begin
                        active_in  = 1'b1;
                        ni_in      = '0;
                        elapsed_in = '0;
                        if (req_ch.task_timeout_ms != '0) begin
                           task_to_in = req_ch.task_timeout_ms;
                        end else if (dexec_ff != '0) begin
                           task_to_in = dexec_ff;
                        end else begin
                           task_to_in = tps_pkg::DEF_EXEC_TMO;
                        end
                     end
                  end
                  tps_pkg::CMD_STOP: begin
                     active_in  = 1'b0;
                     pc_in      = '0;
                     ni_in      = '0;
                     task_to_in = '0;
                  end
                  tps_pkg::CMD_FEEDBACK: begin
                     for (int j = 0; j < JOINTS; j++) begin
                        fb_in[j] = jport[j];
                     end
                     has_fb_in = 1'b1;
                     age_in    = '0;
                  end
                  tps_pkg::CMD_TICK: begin
                     elapsed_in = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TW'(1);
                     age_in     = (age_ff == '1) ? age_ff : age_ff + TW'(1);
                     if (!active_ff) begin
                        res_st_in = tps_pkg::ST_IDLE;
                     end else if (has_fb_ff) begin
                        // walk the final point's joints for the max error
                        paddr_in = PAW'(32'(pc_ff - CNT_W'(1)) * JOINTS);
                        jcnt_in  = '0;
                        state_in = S_ERR_A;
                     end else begin
                        res_err_in = '1;
                        state_in   = S_DECIDE;
                     end
                  end
                  default: begin
                     res_st_in = tps_pkg::ST_REJ_INVALID;
                  end
               endcase
            end
         end

         S_LOAD: begin
            p_we = 1'b1;
            if (jcnt_ff == JW'(JOINTS - 1)) begin
               pc_in    = pc_ff + CNT_W'(1);
               state_in = S_OUT;
            end else begin
               jcnt_in  = jcnt_ff + JW'(1);
               paddr_in = paddr_ff + PAW'(1);
            end
         end

         S_ERR_A: begin
            state_in = S_ERR_B;
         end

         S_ERR_B: begin
            if (adiff[PW-1:0] > res_err_ff) begin
               res_err_in = adiff[PW-1:0];
            end
            if (jcnt_ff == JW'(JOINTS - 1)) begin
               state_in = S_DECIDE;
            end else begin
               jcnt_in  = jcnt_ff + JW'(1);
               paddr_in = paddr_ff + PAW'(1);
               state_in = S_ERR_A;
            end
         end

         S_DECIDE: begin
            state_in = S_DIV;
            if (!has_fb_ff) begin
               res_st_in = tps_pkg::ST_NO_FEEDBACK;
            end else if (age_ff > fbto_eff) begin
               res_st_in = tps_pkg::ST_FB_TIMEOUT;
            end else if (elapsed_ff > task_to_ff) begin
               res_st_in = tps_pkg::ST_EXEC_TIMEOUT;
            end else if (ni_ff < pc_ff) begin
               taddr_in = (ni_ff != '0) ? TAW'(ni_ff - CNT_W'(1)) : '0;
               state_in = S_TIM_A;
            end else if (res_err_ff < {1'b0, tol_eff}) begin
               res_st_in = tps_pkg::ST_FINISHED;
            end else begin
               res_st_in = tps_pkg::ST_AWAIT;
            end
         end

         S_TIM_A: begin
            state_in = S_TIM_B;
         end

         S_TIM_B: begin
            prev_in  = (ni_ff != '0) ? t_rdata : '0;
            taddr_in = TAW'(ni_ff);
            state_in = S_TIM_C;
         end

         S_TIM_C: begin
            state_in = S_TIM_D;
         end

         S_TIM_D: begin
            if (elapsed_ff < prev_ff) begin
               res_st_in = tps_pkg::ST_WAIT;
               state_in  = S_DIV;
            end else begin
               res_intv_in = (t_rdata > prev_ff) ? t_rdata - prev_ff : minint_eff;
               paddr_in    = PAW'(32'(ni_ff) * JOINTS);
               jcnt_in     = '0;
               state_in    = S_POS_A;
            end
         end

         S_POS_A: begin
            state_in = S_POS_B;
         end

         S_POS_B: begin
            res_pos_in[jcnt_ff] = $signed(p_rdata);
            if (jcnt_ff == JW'(JOINTS - 1)) begin
               ni_in     = ni_ff + CNT_W'(1);
               res_st_in = tps_pkg::ST_PUBLISH;
               state_in  = S_DIV;
            end else begin
               jcnt_in  = jcnt_ff + JW'(1);
               paddr_in = paddr_ff + PAW'(1);
               state_in = S_POS_A;
            end
         end

         S_DIV: begin
            // first cycle here starts the divider; its done pulse comes later
            div_start = !div_busy_ff;
            if (div_done) begin
               res_prog_in = (prog_sum > (NUM_W + 1)'(tps_pkg::PROG_CAP))
                             ? 10'(tps_pkg::PROG_CAP) : prog_sum[9:0];
               state_in    = S_OUT;
            end
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign div_busy_in = (state_ff == S_DIV) && !div_done;

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      o_st_in      = o_st_ff;
      o_pos_in     = o_pos_ff;
      o_intv_in    = o_intv_ff;
      o_prog_in    = o_prog_ff;
      o_err_in     = o_err_ff;
      if (rsp_acc) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready)) begin
         rsp_valid_in = 1'b1;
         o_st_in      = res_st_ff;
         o_intv_in    = res_intv_ff;
         o_prog_in    = res_prog_ff;
         o_err_in     = res_err_ff;
         for (int j = 0; j < NJP; j++) begin
            o_pos_in[j] = (j < JOINTS) ? res_pos_ff[j] : '0;
         end
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.status            = o_st_ff;
   assign rsp_ch.cmd_pos_0         = o_pos_ff[0];
   assign rsp_ch.cmd_pos_1         = o_pos_ff[1];
   assign rsp_ch.cmd_pos_2         = o_pos_ff[2];
   assign rsp_ch.cmd_pos_3         = o_pos_ff[3];
   assign rsp_ch.cmd_pos_4         = o_pos_ff[4];
   assign rsp_ch.cmd_pos_5         = o_pos_ff[5];
   assign rsp_ch.interval_ms       = o_intv_ff;
   assign rsp_ch.progress_permille = o_prog_ff;
   assign rsp_ch.peak_error        = o_err_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= tps_pkg::DEF_GOAL_TOL;
         dexec_ff     <= tps_pkg::DEF_EXEC_TMO;
         fbto_ff      <= tps_pkg::DEF_FB_TMO;
         minint_ff    <= tps_pkg::DEF_MIN_INTV;
         active_ff    <= 1'b0;
         pc_ff        <= '0;
         ni_ff        <= '0;
         has_fb_ff    <= 1'b0;
         age_ff       <= '0;
         elapsed_ff   <= '0;
         task_to_ff   <= '0;
         jcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         div_busy_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         dexec_ff     <= dexec_in;
         fbto_ff      <= fbto_in;
         minint_ff    <= minint_in;
         active_ff    <= active_in;
         pc_ff        <= pc_in;
         ni_ff        <= ni_in;
         has_fb_ff    <= has_fb_in;
         age_ff       <= age_in;
         elapsed_ff   <= elapsed_in;
         task_to_ff   <= task_to_in;
         jcnt_ff      <= jcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         div_busy_ff  <= div_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      jin_ff      <= jin_in;
      fb_ff       <= fb_in;
      res_pos_ff  <= res_pos_in;
      paddr_ff    <= paddr_in;
      taddr_ff    <= taddr_in;
      prev_ff     <= prev_in;
      res_st_ff   <= res_st_in;
      res_intv_ff <= res_intv_in;
      res_prog_ff <= res_prog_in;
      res_err_ff  <= res_err_in;
      o_st_ff     <= o_st_in;
      o_pos_ff    <= o_pos_in;
      o_intv_ff   <= o_intv_in;
      o_prog_ff   <= o_prog_in;
      o_err_ff    <= o_err_in;
   end

   // ------------------------------------------------------------------
   // Point storage and progress divider
   // ------------------------------------------------------------------
   tps_ram #(
      .WIDTH (TW),
      .DEPTH (MAX_POINTS),
      .AW    (TAW)
   ) u_time_ram (
      .clock (clock),
      .we    (t_we),
      .waddr (TAW'(pc_ff)),
      .wdata (req_ch.point_time_ms),
      .raddr (taddr_ff),
      .rdata (t_rdata)
   );

   tps_ram #(
      .WIDTH (PW),
      .DEPTH (PDEPTH),
      .AW    (PAW)
   ) u_pos_ram (
      .clock (clock),
      .we    (p_we),
      .waddr (paddr_ff),
      .wdata (jin_ff[jcnt_ff]),
      .raddr (paddr_ff),
      .rdata (p_rdata)
   );

   tps_div #(
      .NUM_W (NUM_W),
      .DEN_W (CNT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (pc_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `TPS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_acc, !req_ch.ready)
   `TPS_ASSERT_IMPL(a_active_has_points, clock, reset, active_ff, pc_ff != '0)
   `TPS_ASSERT_IMPL(a_index_in_range, clock, reset, 1'b1, ni_ff <= pc_ff)
   `TPS_ASSERT_IMPL(a_publish_interval, clock, reset,
                    rsp_ch.valid && (rsp_ch.status == tps_pkg::ST_PUBLISH),
                    rsp_ch.interval_ms != '0)

endmodule

[bench/tb_trajectory_point_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_trajectory_point_sequencer
// Drives command items with random gaps and result stalls, predicts each
// result with an in-bench copy of the sequencer and compares field by field.
// ----------------------------------------------------------------------------
module tb_trajectory_point_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 80;     // outlasts the longest tick
   localparam int MAXP           = tps_pkg::MAX_POINTS_DEF;

   typedef struct {
      logic [2:0]         cmd;
      logic [23:0]        ptime;
      logic [23:0]        tmo;
      logic signed [31:0] joint [6];
   } cmd_item_type;

   typedef struct {
      logic [3:0]         status;
      logic signed [31:0] pos [6];
      logic [23:0]        interval;
      logic [9:0]         progress;
      logic [31:0]        peak_err;
   } point_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [tps_pkg::CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   tps_req_if req_ch ();
   tps_rsp_if rsp_ch ();

   trajectory_point_sequencer dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow copy of the sequencer: registers and control state
   // ---------------------------------------------------------------------
   logic [30:0] goal_tol;
   logic [23:0] exec_tmo_reg, fb_tmo_reg, min_intv_reg;

   bit                 seq_active;
   int unsigned        pt_count, nxt_idx;
   logic [23:0]        pt_time [MAXP];
   logic signed [31:0] pt_pos  [MAXP][6];
   logic signed [31:0] fb_pos  [6];
   bit                 fb_valid;
   logic [23:0]        fb_age, elapsed, task_tmo;

   point_result_type pending_results [$];
   int  fail_count  = 0;
   int  items_sent  = 0;
   bit  calm        = 0;   // no gaps and no stalls while set
   int  quiet_cycles = 0;

   function automatic logic [23:0] sat_inc24(logic [23:0] v);
      return (v == 24'hFFFFFF) ? v : v + 24'd1;
   endfunction

   function automatic int unsigned permille_now();
      int unsigned p;
      if (!seq_active || pt_count == 0) return 0;
      p = tps_pkg::PROG_BASE + (tps_pkg::PROG_SPAN * nxt_idx) / pt_count;
      return (p > tps_pkg::PROG_CAP) ? tps_pkg::PROG_CAP : p;
   endfunction

   // largest |feedback - final point| over the joints
   function automatic logic [31:0] final_error();
      logic [31:0] best;
      longint d;
      if (!fb_valid) return 32'hFFFFFFFF;
      if (pt_count == 0) return 0;
      best = 0;
      for (int j = 0; j < 6; j++) begin
         d = longint'(fb_pos[j]) - longint'(pt_pos[pt_count-1][j]);
         if (d < 0) d = -d;
         if (d[31:0] > best) best = d[31:0];
      end
      return best;
   endfunction

   function automatic point_result_type predict_result(cmd_item_type it);
      point_result_type r;
      logic [23:0] prev, cur, lim;
      logic [30:0] tol;
      r.status = tps_pkg::ST_OK;
      for (int j = 0; j < 6; j++) r.pos[j] = 0;
      r.interval = 0;
      r.progress = 0;
      r.peak_err = 0;
      case (it.cmd)
         tps_pkg::CMD_LOAD: begin
            if (seq_active) r.status = tps_pkg::ST_REJ_BUSY;
            else if (pt_count >= MAXP) r.status = tps_pkg::ST_REJ_INVALID;
            else begin
               pt_time[pt_count] = it.ptime;
               for (int j = 0; j < 6; j++) pt_pos[pt_count][j] = it.joint[j];
               pt_count++;
            end
         end
         tps_pkg::CMD_START: begin
            if (seq_active) r.status = tps_pkg::ST_REJ_BUSY;
            else if (pt_count == 0) r.status = tps_pkg::ST_REJ_EMPTY;
            else begin
               seq_active = 1;
               nxt_idx = 0;
               elapsed = 0;
               task_tmo = (it.tmo != 0) ? it.tmo :
                          (exec_tmo_reg != 0) ? exec_tmo_reg : tps_pkg::DEF_EXEC_TMO;
            end
         end
         tps_pkg::CMD_STOP: begin
            seq_active = 0;
            pt_count = 0;
            nxt_idx = 0;
            task_tmo = 0;
         end
         tps_pkg::CMD_FEEDBACK: begin
            for (int j = 0; j < 6; j++) fb_pos[j] = it.joint[j];
            fb_valid = 1;
            fb_age = 0;
         end
         tps_pkg::CMD_TICK: begin
            elapsed = sat_inc24(elapsed);
            fb_age  = sat_inc24(fb_age);
            lim = (fb_tmo_reg != 0) ? fb_tmo_reg : tps_pkg::DEF_FB_TMO;
            tol = (goal_tol != 0) ? goal_tol : tps_pkg::DEF_GOAL_TOL;
            if (!seq_active) r.status = tps_pkg::ST_IDLE;
            else begin
               r.progress = permille_now();
               r.peak_err = final_error();
               if (!fb_valid) r.status = tps_pkg::ST_NO_FEEDBACK;
               else if (fb_age > lim) r.status = tps_pkg::ST_FB_TIMEOUT;
               else if (elapsed > task_tmo) r.status = tps_pkg::ST_EXEC_TIMEOUT;
               else if (nxt_idx < pt_count) begin
                  prev = (nxt_idx != 0) ? pt_time[nxt_idx-1] : 24'd0;
                  cur  = pt_time[nxt_idx];
                  if (elapsed < prev) r.status = tps_pkg::ST_WAIT;
                  else begin
                     r.interval = (cur > prev) ? cur - prev :
                                  (min_intv_reg != 0) ? min_intv_reg : tps_pkg::DEF_MIN_INTV;
                     for (int j = 0; j < 6; j++) r.pos[j] = pt_pos[nxt_idx][j];
                     nxt_idx++;
                     r.status = tps_pkg::ST_PUBLISH;
                     r.progress = permille_now();
                  end
               end else begin
                  r.status = (r.peak_err < {1'b0, tol}) ? tps_pkg::ST_FINISHED
                                                        : tps_pkg::ST_AWAIT;
               end
            end
         end
         default: r.status = tps_pkg::ST_REJ_INVALID;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      point_result_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result item", rsp_ch.status, -1);
         end else begin
            e = pending_results.pop_front();
            if (rsp_ch.status !== e.status) report_mismatch("status", rsp_ch.status, e.status);
            if (rsp_ch.cmd_pos_0 !== e.pos[0]) report_mismatch("cmd_pos_0", rsp_ch.cmd_pos_0, e.pos[0]);
            if (rsp_ch.cmd_pos_1 !== e.pos[1]) report_mismatch("cmd_pos_1", rsp_ch.cmd_pos_1, e.pos[1]);
            if (rsp_ch.cmd_pos_2 !== e.pos[2]) report_mismatch("cmd_pos_2", rsp_ch.cmd_pos_2, e.pos[2]);
            if (rsp_ch.cmd_pos_3 !== e.pos[3]) report_mismatch("cmd_pos_3", rsp_ch.cmd_pos_3, e.pos[3]);
            if (rsp_ch.cmd_pos_4 !== e.pos[4]) report_mismatch("cmd_pos_4", rsp_ch.cmd_pos_4, e.pos[4]);
            if (rsp_ch.cmd_pos_5 !== e.pos[5]) report_mismatch("cmd_pos_5", rsp_ch.cmd_pos_5, e.pos[5]);
            if (rsp_ch.interval_ms !== e.interval)
               report_mismatch("interval_ms", rsp_ch.interval_ms, e.interval);
            if (rsp_ch.progress_permille !== e.progress)
               report_mismatch("progress_permille", rsp_ch.progress_permille, e.progress);
            if (rsp_ch.peak_error !== e.peak_err)
               report_mismatch("peak_error", rsp_ch.peak_error, e.peak_err);
         end
      end
   end

   // result side back-pressure: a fresh stall draw for every item
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   // watchdog: cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("trajectory_point_sequencer test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Command side
   // ---------------------------------------------------------------------
   task automatic send_item(cmd_item_type it);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.cmd             = it.cmd;
      req_ch.point_time_ms   = it.ptime;
      req_ch.task_timeout_ms = it.tmo;
      req_ch.joint_0 = it.joint[0];
      req_ch.joint_1 = it.joint[1];
      req_ch.joint_2 = it.joint[2];
      req_ch.joint_3 = it.joint[3];
      req_ch.joint_4 = it.joint[4];
      req_ch.joint_5 = it.joint[5];
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(predict_result(it));
      items_sent++;
   endtask

   task automatic release_req();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   function automatic cmd_item_type make_item(logic [2:0] c, logic [23:0] t = 0,
                                              logic [23:0] tmo = 0);
      cmd_item_type it;
      it.cmd = c;
      it.ptime = t;
      it.tmo = tmo;
      for (int j = 0; j < 6; j++) it.joint[j] = $urandom;
      return it;
   endfunction

   task automatic send_cmd(logic [2:0] c, logic [23:0] t = 0, logic [23:0] tmo = 0);
      send_item(make_item(c, t, tmo));
   endtask

   // wait for every result, then for a tick that may still be in work
   task automatic drain();
      release_req();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [tps_pkg::CSR_IW-1:0] idx, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
      paddr = tps_pkg::CSR_AW'(idx) << 2;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         tps_pkg::REG_GOAL_TOL: goal_tol     = value[30:0];
         tps_pkg::REG_EXEC_TMO: exec_tmo_reg = value[23:0];
         tps_pkg::REG_FB_TMO:   fb_tmo_reg   = value[23:0];
         default:               min_intv_reg = value[23:0];
      endcase
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic set_regs(logic [31:0] tol, logic [31:0] ex, logic [31:0] fb,
                           logic [31:0] mi);
      drain();
      csr_write(tps_pkg::REG_GOAL_TOL, tol);
      csr_write(tps_pkg::REG_EXEC_TMO, ex);
      csr_write(tps_pkg::REG_FB_TMO, fb);
      csr_write(tps_pkg::REG_MIN_INTV, mi);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      cmd_item_type it;
      send_cmd(tps_pkg::CMD_TICK);              // idle tick
      send_cmd(tps_pkg::CMD_START);             // empty trajectory
      send_cmd(3'd5);                           // unknown commands
      send_cmd(3'd7);
      send_cmd(tps_pkg::CMD_STOP);
      it = make_item(tps_pkg::CMD_LOAD, 24'd0); // first point at time zero
      for (int j = 0; j < 6; j++) it.joint[j] = 32'sh7FFFFFFF;
      send_item(it);
      it = make_item(tps_pkg::CMD_LOAD, 24'hFFFFFF);
      for (int j = 0; j < 6; j++) it.joint[j] = 32'sh80000000;
      send_item(it);
      it = make_item(tps_pkg::CMD_LOAD, 24'd3); // time goes backwards
      for (int j = 0; j < 6; j++) it.joint[j] = 32'sh80000000;
      send_item(it);
      send_cmd(tps_pkg::CMD_START, 0, 24'hFFFFFF);
      send_cmd(tps_pkg::CMD_TICK);              // no feedback yet
      it = make_item(tps_pkg::CMD_FEEDBACK);    // worst case error, all ones
      for (int j = 0; j < 6; j++) it.joint[j] = 32'sh7FFFFFFF;
      send_item(it);
      send_cmd(tps_pkg::CMD_START);             // busy
      send_cmd(tps_pkg::CMD_LOAD, 24'd5);       // busy
      repeat (4) send_cmd(tps_pkg::CMD_TICK);   // publish, then wait on huge time
      send_cmd(tps_pkg::CMD_STOP);
      send_cmd(tps_pkg::CMD_LOAD, 24'd1);
      send_cmd(tps_pkg::CMD_START, 24'd0, 24'd1);   // one ms task timeout
      send_cmd(tps_pkg::CMD_FEEDBACK);
      repeat (3) send_cmd(tps_pkg::CMD_TICK);   // publish, then execution timeout
      send_cmd(tps_pkg::CMD_STOP);
   endtask

   // fill the table, then one more load is refused
   task automatic test_full_table();
      calm = 1;
      send_cmd(tps_pkg::CMD_STOP);
      for (int i = 0; i <= MAXP; i++) send_cmd(tps_pkg::CMD_LOAD, 24'(i));
      send_cmd(tps_pkg::CMD_START, 0, 24'd200);
      send_cmd(tps_pkg::CMD_FEEDBACK);
      repeat (MAXP + 3) send_cmd(tps_pkg::CMD_TICK);
      send_cmd(tps_pkg::CMD_STOP);
      calm = 0;
   endtask

   // one well formed run: load, feedback, start, ticks, with some noise mixed in
   task automatic run_trajectory();
      int n, t, ticks;
      cmd_item_type it, fin;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, MAXP) : $urandom_range(1, 8);
      t = 0;
      send_cmd(tps_pkg::CMD_STOP);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) t = (t > 2) ? t - $urandom_range(0, 2) : t;
         else t += $urandom_range(0, 4);
         fin = make_item(tps_pkg::CMD_LOAD, 24'(t));
         send_item(fin);
      end
      // feedback close to the final point, sometimes far off or missing
      it = make_item(tps_pkg::CMD_FEEDBACK);
      if ($urandom_range(0, 3) != 0)
         for (int j = 0; j < 6; j++)
            it.joint[j] = fin.joint[j] + $signed(32'($urandom_range(0, 30000)) - 32'd15000);
      if ($urandom_range(0, 7) != 0) send_item(it);
      send_cmd(tps_pkg::CMD_START, 0,
               ($urandom_range(0, 3) == 0) ? 24'($urandom_range(1, 40)) : 24'd0);
      ticks = t + $urandom_range(1, 12);
      for (int k = 0; k < ticks; k++) begin
         case ($urandom_range(0, 19))
            0: send_item(it);
            1: send_item(make_item(3'($urandom_range(0, 7)), 24'($urandom),
                                   24'($urandom)));
            default: send_cmd(tps_pkg::CMD_TICK);
         endcase
      end
   endtask

   task automatic test_random(int target);
      while (items_sent < target) begin
         if ($urandom_range(0, 4) == 0) calm = ~calm;
         run_trajectory();
      end
      calm = 0;
   endtask

   task automatic test_register_settings();
      set_regs(32'd0, 32'd0, 32'd0, 32'd0);                        // zero selects defaults
      test_random(items_sent + 150);
      set_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      test_random(items_sent + 150);
      set_regs(32'd1, 32'd1, 32'd1, 32'd1);                         // stale feedback fast
      test_random(items_sent + 150);
      set_regs(32'h7FFFFFFF, 32'd30, 32'd6, 32'h00FFFFFF);
      test_random(items_sent + 150);
      set_regs($urandom, $urandom, 32'($urandom_range(2, 40)), $urandom);
      test_random(items_sent + 150);
      set_regs(32'd10486, 32'd15000, 32'd1000, 32'd20);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.cmd = '0;
      req_ch.point_time_ms = '0;
      req_ch.task_timeout_ms = '0;
      req_ch.joint_0 = '0; req_ch.joint_1 = '0; req_ch.joint_2 = '0;
      req_ch.joint_3 = '0; req_ch.joint_4 = '0; req_ch.joint_5 = '0;
      goal_tol = tps_pkg::DEF_GOAL_TOL;
      exec_tmo_reg = tps_pkg::DEF_EXEC_TMO;
      fb_tmo_reg = tps_pkg::DEF_FB_TMO;
      min_intv_reg = tps_pkg::DEF_MIN_INTV;
      seq_active = 0; pt_count = 0; nxt_idx = 0;
      fb_valid = 0; fb_age = 0; elapsed = 0; task_tmo = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_full_table();
      test_random(420);
      test_register_settings();
      test_random(1300);

      drain();
      if (fail_count == 0) $display("trajectory_point_sequencer test passed");
      else $display("trajectory_point_sequencer test failed");
      $finish;
   end

endmodule
